// File: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rti_pkg.sv
// Shared types and constants of the trilinear interpolation block.
package rti_pkg;

    localparam int AXIS_POINTS_DEF  = 16;
    localparam int GRID_ENTRIES_DEF = 4096;
    localparam int WORD_BITS_DEF    = 32;

    localparam int CMD_BITS     = 3;
    localparam int SLOT_BITS    = 12;
    localparam int CFG_BITS     = 5;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(16);

    localparam int FRAC_BITS  = 16;
    localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam int FRAC_HALF  = 1 << (FRAC_BITS - 1);
    // two quotient bits per divider stage, plus one classify stage
    localparam int DIV_STAGES = FRAC_BITS / 2;
    localparam int DIV_LAT    = DIV_STAGES + 1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD_X   = 3'd0,
        CMD_LOAD_Y   = 3'd1,
        CMD_LOAD_Z   = 3'd2,
        CMD_LOAD_VAL = 3'd3,
        CMD_QUERY    = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_POINTS_X = 2'd0,
        CFG_POINTS_Y = 2'd1,
        CFG_POINTS_Z = 2'd2
    } t_cfg_idx;

    localparam t_cmd AXIS_CMD [3] = '{CMD_LOAD_X, CMD_LOAD_Y, CMD_LOAD_Z};

    typedef struct packed {
        logic                 vld;
        logic [CMD_BITS-1:0]  cmd;
        logic [SLOT_BITS-1:0] slot;
    } t_meta;

endpackage

// File: hdl/rti_ram.sv
// Generic RAM: one write port, two registered read ports.
module rti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

// File: hdl/rti_div.sv
// Pipelined fraction divider: floor(num * 2^16 / den), saturated to 0..1.
module rti_div #(
    parameter int WORD_BITS = rti_pkg::WORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [WORD_BITS:0]  i_num,
    input  logic signed [WORD_BITS:0]  i_den,
    output logic [rti_pkg::FRAC_BITS:0] o_frac
);
    import rti_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int NS  = DIV_STAGES;
    localparam int SPS = FRAC_BITS / NS;

    logic                 r_zero [0:NS];
    logic                 r_one  [0:NS];
    logic [W-1:0]         r_rem  [0:NS];
    logic [W-1:0]         r_den  [0:NS];
    logic [FRAC_BITS-1:0] r_q    [0:NS];
    logic [W-1:0]         n_rem  [1:NS];
    logic [FRAC_BITS-1:0] n_q    [1:NS];
    logic                 n_zero;
    logic                 n_one;

    // non-positive width or non-positive offset gives zero; offset at or past the
    // cell width gives exactly one
    assign n_zero = (i_den <= 0) || (i_num <= 0);
    assign n_one  = !n_zero && (i_num >= i_den);

    always_comb begin
        logic [W:0]           t;
        logic [W-1:0]         rm;
        logic [FRAC_BITS-1:0] q;
        for (int s = 1; s <= NS; s++) begin
            rm = r_rem[s-1];
            q  = r_q[s-1];
            for (int b = 0; b < SPS; b++) begin
                t = {rm, 1'b0};
                if (t >= {1'b0, r_den[s-1]}) begin
                    rm = W'(t - {1'b0, r_den[s-1]});
                    q  = {q[FRAC_BITS-2:0], 1'b1};
                end else begin
                    rm = t[W-1:0];
                    q  = {q[FRAC_BITS-2:0], 1'b0};
                end
            end
            n_rem[s] = rm;
            n_q[s]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= n_zero;
            r_one[0]  <= n_one;
            r_rem[0]  <= i_num[W-1:0];
            r_den[0]  <= i_den[W-1:0];
            r_q[0]    <= '0;
            for (int s = 1; s <= NS; s++) begin
                r_zero[s] <= r_zero[s-1];
                r_one[s]  <= r_one[s-1];
                r_den[s]  <= r_den[s-1];
                r_rem[s]  <= n_rem[s];
                r_q[s]    <= n_q[s];
            end
        end
    end

    assign o_frac = r_one[NS]  ? FRAC_ONE :
                    r_zero[NS] ? '0 : {1'b0, r_q[NS]};
endmodule

// File: hdl/rectilinear_trilinear_interp_top.sv
// Top level of the rectilinear-grid trilinear interpolator.
//
// Trilinear interpolation over a rectilinear grid. Load beats (cmd 0..3) write the
// x, y and z axis point lists and the flattened value grid (x major, z minor);
// a query beat (cmd 4) returns one result beat with the blended Q16.16 value and
// an in-range flag, or zero with the flag clear when the point lies outside the
// axis bounds. Load beats and unused commands return nothing. The block is a
// fixed 18-stage pipeline: one beat enters every cycle unless a held result
// stalls the output, so the sustained rate is one beat per cycle. The depth is
// set by the axis compare and search stages, the 9-stage fraction divider (a
// classify stage, then two quotient bits per stage), the grid read and the three
// levels of multiply-then-round blending. The eight corners are read together
// from four identical copies of the grid RAM, each with two read ports. A stall
// on the output while a result is held freezes the whole pipeline and shows on
// the input stall. Axis and grid stores start undefined and need no clearing
// pass. Write the points_x/y/z registers only while the pipeline is empty.
module rectilinear_trilinear_interp_top #(
    parameter int AXIS_POINTS  = rti_pkg::AXIS_POINTS_DEF,
    parameter int GRID_ENTRIES = rti_pkg::GRID_ENTRIES_DEF,
    parameter int WORD_BITS    = rti_pkg::WORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [rti_pkg::CMD_BITS-1:0]      i_cmd,
    input  logic [rti_pkg::SLOT_BITS-1:0]     i_slot,
    input  logic signed [WORD_BITS-1:0]       i_load_word,
    input  logic signed [WORD_BITS-1:0]       i_query_x,
    input  logic signed [WORD_BITS-1:0]       i_query_y,
    input  logic signed [WORD_BITS-1:0]       i_query_z,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [WORD_BITS-1:0]       o_interp_value,
    output logic                              o_in_range,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rti_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [rti_pkg::CFG_BITS-1:0]      i_cfg_data
);
    import rti_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int P   = AXIS_POINTS;
    localparam int AI  = $clog2(P);
    localparam int NB  = AI + 1;
    localparam int GA  = $clog2(GRID_ENTRIES);
    localparam int PW  = 3 * AI + 4;
    localparam int FW  = FRAC_BITS + 1;
    localparam int PRW = W + FRAC_BITS + 3;

    // stage numbers: the register at the end of each step
    localparam int ST_CMP  = 1;
    localparam int ST_IDX  = 2;
    localparam int ST_DIFF = 3;
    localparam int ST_POS  = 4;
    localparam int ST_GRD  = ST_DIFF + DIV_LAT - 1;
    localparam int ST_CRN  = ST_GRD + 1;
    localparam int ST_ZM   = ST_CRN + 1;
    localparam int ST_ZA   = ST_ZM + 1;
    localparam int ST_YM   = ST_ZA + 1;
    localparam int ST_YA   = ST_YM + 1;
    localparam int ST_XM   = ST_YA + 1;
    localparam int ST_OUT  = ST_XM + 1;

    // blend helpers: lerp(p, q, f) = p + floor(((q - p) * f + half) / one)
    function automatic logic signed [PRW-1:0] lerp_mul(input logic signed [W-1:0] p,
                                                       input logic signed [W-1:0] q,
                                                       input logic [FW-1:0] f);
        logic signed [W:0] d;
        d = (W+1)'(q) - (W+1)'(p);
        return PRW'(d) * $signed({1'b0, f});
    endfunction

    function automatic logic signed [W-1:0] lerp_add(input logic signed [W-1:0] p,
                                                     input logic signed [PRW-1:0] prod);
        logic signed [PRW-1:0] s;
        s = prod + PRW'(FRAC_HALF);
        return W'((s >>> FRAC_BITS) + PRW'(p));
    endfunction

    // ---------------------------------------------------------------- control
    logic  adv;
    logic  in_acc;
    t_meta r_meta [1:ST_OUT-1];
    t_meta n_meta;
    logic  r_out_valid;

    // whole pipeline advances unless a finished result is held by the sink
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign adv         = !o_in_stall;
    assign in_acc      = i_in_valid && adv;
    assign o_cfg_ready = 1'b1;

    assign n_meta = '{vld: i_in_valid, cmd: i_cmd, slot: i_slot};

    // ---------------------------------------------------------- configuration
    logic [CFG_BITS-1:0] r_pts [3];
    logic [NB-1:0]       npts  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) r_pts[a] <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POINTS_X: r_pts[0] <= i_cfg_data;
                CFG_POINTS_Y: r_pts[1] <= i_cfg_data;
                CFG_POINTS_Z: r_pts[2] <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // clamp point counts to 2..AXIS_POINTS
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (int'(r_pts[a]) < 2) npts[a] = NB'(2);
            else if (int'(r_pts[a]) > P) npts[a] = NB'(P);
            else npts[a] = NB'(r_pts[a]);
        end
    end

    logic [2*NB-1:0] sx;
    assign sx = (2*NB)'(npts[1]) * (2*NB)'(npts[2]);

    // load word travels down the pipe to the axis and grid writes
    logic signed [W-1:0] r_word [ST_CMP:ST_GRD];
    logic [W-1:0]        r_crd_word_cmp;

    assign r_crd_word_cmp = r_word[ST_CMP];

    // ------------------------------------------------- step 1: axis compares
    logic signed [W-1:0] r_ax [3][P];
    logic signed [W-1:0] crd_in [3];
    logic [P-1:0]        n_ge [3];
    logic                n_lo [3];
    logic [P-1:0]        r_ge [3];
    logic                r_lo [3];
    logic signed [W-1:0] r_crd [ST_CMP:ST_IDX][3];

    assign crd_in[0] = i_query_x;
    assign crd_in[1] = i_query_y;
    assign crd_in[2] = i_query_z;

    // compare copy of the axis lists, written as load beats are accepted
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            if (in_acc && i_cmd == AXIS_CMD[a] && int'(i_slot) < P) begin
                r_ax[a][AI'(i_slot)] <= i_load_word;
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_lo[a] = crd_in[a] >= r_ax[a][0];
            for (int k = 0; k < P; k++) n_ge[a][k] = r_ax[a][k] >= crd_in[a];
        end
    end

    // -------------------------------------------- step 2: lower-bound search
    logic [AI-1:0]       n_idx [3];
    logic                n_rng;
    logic [AI-1:0]       r_idx [3];
    logic                r_rng [ST_IDX:ST_OUT-1];
    logic signed [W-1:0] a_lo [3];
    logic signed [W-1:0] a_hi [3];

    always_comb begin
        logic [P-1:0]  m;
        logic [AI-1:0] ix;
        logic [AI-1:0] last;
        n_rng = 1'b1;
        for (int a = 0; a < 3; a++) begin
            last = AI'(npts[a] - NB'(1));
            for (int k = 0; k < P; k++) m[k] = r_ge[a][k] && (k < int'(npts[a]));
            ix = last;
            for (int k = P - 1; k >= 0; k--) begin
                if (m[k]) ix = AI'(k);
            end
            // a point on the first axis point uses the first cell
            if (ix == '0) ix = AI'(1);
            n_idx[a] = ix;
            n_rng    = n_rng && r_lo[a] && r_ge[a][last];
        end
    end

    // read copy of the axis lists: cell edges at idx-1 and idx
    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [W-1:0] rd_lo;
        logic [W-1:0] rd_hi;
        rti_ram #(.WIDTH(W), .DEPTH(P)) u_ram (
            .i_clk     (i_clk),
            .i_we      (adv && r_meta[ST_CMP].vld && r_meta[ST_CMP].cmd == AXIS_CMD[a]
                        && int'(r_meta[ST_CMP].slot) < P),
            .i_waddr   (AI'(r_meta[ST_CMP].slot)),
            .i_wdata   (r_crd_word_cmp),
            .i_re      (adv),
            .i_raddr_a (n_idx[a] - AI'(1)),
            .i_raddr_b (n_idx[a]),
            .o_rdata_a (rd_lo),
            .o_rdata_b (rd_hi)
        );
        assign a_lo[a] = $signed(rd_lo);
        assign a_hi[a] = $signed(rd_hi);
    end

    // ---------------------------------- step 3: offsets, widths, grid strides
    logic signed [W:0]   n_num [3];
    logic signed [W:0]   n_den [3];
    logic signed [W:0]   r_num [3];
    logic signed [W:0]   r_den [3];
    logic [PW-1:0]       r_offx;
    logic [PW-1:0]       r_offy;
    logic [AI-1:0]       r_izm1;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_num[a] = (W+1)'(r_crd[ST_IDX][a]) - (W+1)'(a_lo[a]);
            n_den[a] = (W+1)'(a_hi[a]) - (W+1)'(a_lo[a]);
        end
    end

    // ------------------------------------------------ fraction dividers
    logic [FW-1:0] frac [3];

    for (genvar a = 0; a < 3; a++) begin : g_div
        rti_div #(.WORD_BITS(W)) u_div (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_num  (r_num[a]),
            .i_den  (r_den[a]),
            .o_frac (frac[a])
        );
    end

    // --------------------------------------- step 4 on: corner base, grid read
    logic [PW-1:0] r_pos [ST_POS:ST_GRD];
    logic [PW-1:0] caddr [8];
    logic [7:0]    n_omask;
    logic [7:0]    r_omask;
    logic [W-1:0]  crd_a [4];
    logic [W-1:0]  crd_b [4];

    always_comb begin
        logic [PW-1:0] base;
        for (int j = 0; j < 4; j++) begin
            base = r_pos[ST_GRD];
            if (j[0]) base = base + PW'(npts[2]);
            if (j[1]) base = base + PW'(sx);
            caddr[2*j]   = base;
            caddr[2*j+1] = base + PW'(1);
        end
        // corners beyond the grid read as zero
        for (int c = 0; c < 8; c++) n_omask[c] = 32'(caddr[c]) >= GRID_ENTRIES;
    end

    // four copies of the grid, all written alike, give eight reads a cycle while the pipe advances
    for (genvar j = 0; j < 4; j++) begin : g_grid
        rti_ram #(.WIDTH(W), .DEPTH(GRID_ENTRIES)) u_ram (
            .i_clk     (i_clk),
            .i_we      (adv && r_meta[ST_GRD].vld && r_meta[ST_GRD].cmd == CMD_LOAD_VAL
                        && int'(r_meta[ST_GRD].slot) < GRID_ENTRIES),
            .i_waddr   (GA'(r_meta[ST_GRD].slot)),
            .i_wdata   (r_word[ST_GRD]),
            .i_re      (adv),
            .i_raddr_a (GA'(caddr[2*j])),
            .i_raddr_b (GA'(caddr[2*j+1])),
            .o_rdata_a (crd_a[j]),
            .o_rdata_b (crd_b[j])
        );
    end

    // ------------------------------------------------------- blend stages
    logic signed [W-1:0]   r_zp    [4];
    logic signed [PRW-1:0] r_zprod [4];
    logic signed [W-1:0]   r_zc    [4];
    logic signed [W-1:0]   r_yp    [2];
    logic signed [PRW-1:0] r_yprod [2];
    logic signed [W-1:0]   r_yc    [2];
    logic signed [W-1:0]   r_xp;
    logic signed [PRW-1:0] r_xprod;
    logic [FW-1:0]         r_fy [ST_ZM:ST_ZA];
    logic [FW-1:0]         r_fx [ST_ZM:ST_YA];
    logic signed [W-1:0]   r_out_value;
    logic                  r_out_range;
    logic signed [W-1:0]   cp [4];
    logic signed [W-1:0]   cq [4];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            cp[j] = r_omask[2*j]   ? '0 : $signed(crd_a[j]);
            cq[j] = r_omask[2*j+1] ? '0 : $signed(crd_b[j]);
        end
    end

    // ------------------------------------------------------- control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s < ST_OUT; s++) r_meta[s] <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_meta[1] <= n_meta;
            for (int s = 2; s < ST_OUT; s++) r_meta[s] <= r_meta[s-1];
            r_out_valid <= r_meta[ST_OUT-1].vld && r_meta[ST_OUT-1].cmd == CMD_QUERY;
        end
    end

    // ------------------------------------------------------- payload regs
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // step 1
            r_word[ST_CMP] <= i_load_word;
            for (int s = ST_CMP + 1; s <= ST_GRD; s++) r_word[s] <= r_word[s-1];
            for (int a = 0; a < 3; a++) begin
                r_crd[ST_CMP][a] <= crd_in[a];
                r_crd[ST_IDX][a] <= r_crd[ST_CMP][a];
                r_ge[a]          <= n_ge[a];
                r_lo[a]          <= n_lo[a];
                // step 2
                r_idx[a]         <= n_idx[a];
                // step 3
                r_num[a]         <= n_num[a];
                r_den[a]         <= n_den[a];
            end
            r_rng[ST_IDX] <= n_rng;
            for (int s = ST_IDX + 1; s < ST_OUT; s++) r_rng[s] <= r_rng[s-1];
            r_offx <= PW'(r_idx[0] - AI'(1)) * PW'(sx);
            r_offy <= PW'(r_idx[1] - AI'(1)) * PW'(npts[2]);
            r_izm1 <= r_idx[2] - AI'(1);
            // step 4 and the wait for the dividers
            r_pos[ST_POS] <= r_offx + r_offy + PW'(r_izm1);
            for (int s = ST_POS + 1; s <= ST_GRD; s++) r_pos[s] <= r_pos[s-1];
            r_omask <= n_omask;
            // z blend
            for (int j = 0; j < 4; j++) begin
                r_zp[j]    <= cp[j];
                r_zprod[j] <= lerp_mul(cp[j], cq[j], frac[2]);
                r_zc[j]    <= lerp_add(r_zp[j], r_zprod[j]);
            end
            r_fy[ST_ZM] <= frac[1];
            r_fy[ST_ZA] <= r_fy[ST_ZM];
            r_fx[ST_ZM] <= frac[0];
            for (int s = ST_ZM + 1; s <= ST_YA; s++) r_fx[s] <= r_fx[s-1];
            // y blend
            for (int j = 0; j < 2; j++) begin
                r_yp[j]    <= r_zc[2*j];
                r_yprod[j] <= lerp_mul(r_zc[2*j], r_zc[2*j+1], r_fy[ST_ZA]);
                r_yc[j]    <= lerp_add(r_yp[j], r_yprod[j]);
            end
            // x blend and result; out-of-range points give zero
            r_xp        <= r_yc[0];
            r_xprod     <= lerp_mul(r_yc[0], r_yc[1], r_fx[ST_YA]);
            r_out_value <= r_rng[ST_OUT-1] ? lerp_add(r_xp, r_xprod) : '0;
            r_out_range <= r_rng[ST_OUT-1];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_interp_value = r_out_value;
    assign o_in_range     = r_out_range;
endmodule

// File: hdl/rti_chk.sv
// Port-level checker for the trilinear interpolator, bound to the top level.
`include "assert_macros.svh"

module rti_chk #(
    parameter int WORD_BITS = rti_pkg::WORD_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_stall,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic signed [WORD_BITS-1:0] o_interp_value,
    input logic                        o_in_range
);
    // hold a stalled result beat
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_interp_value) && $stable(o_in_range), "stalled result beat changed")

    // out-of-range points return zero
    `ASSERT_IMPLIES(a_zero_oor, i_clk, i_rst_n, o_out_valid && !o_in_range, o_interp_value == '0, "out-of-range result not zero")

    // input stalls only behind a held result
    `ASSERT_IMPLIES(a_stall_src, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stall without a held result")

    // a taken result frees the input side in the same cycle
    `ASSERT_ALWAYS(a_no_stall_free, i_clk, i_rst_n, !(o_in_stall && !i_out_stall), "input stall while output flows")
endmodule

bind rectilinear_trilinear_interp_top rti_chk #(.WORD_BITS(WORD_BITS)) u_rti_chk (.*);

// File: dv/rectilinear_trilinear_interp_top_tb.sv
// Self-checking testbench of the rectilinear-grid trilinear interpolator.
`timescale 1ns / 1ps

module rectilinear_trilinear_interp_top_tb;
    import rti_pkg::*;

    localparam int NAXIS = AXIS_POINTS_DEF;
    localparam int NGRID = GRID_ENTRIES_DEF;
    localparam logic [CMD_BITS-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_SPARE_HI = 3'd7;
    localparam int  ONE_Q16      = 65536;
    localparam int  DRAIN_CYCLES = 24;       // pipeline is 18 deep
    localparam int  HOLD_CYCLES  = 400;
    localparam int  HOLD_AFTER   = 300;      // results seen before the long hold
    localparam longint CYCLE_LIMIT = 500000;

    typedef struct {
        logic [CMD_BITS-1:0]  cmd;
        logic [SLOT_BITS-1:0] slot;
        logic signed [31:0]   word;
        logic signed [31:0]   x, y, z;
    } t_beat;

    typedef struct {
        logic signed [31:0] value;
        logic               in_range;
    } t_interp;

    // Scoreboard: mirrors the tables and registers, predicts each query result.
    class interp_scoreboard;
        longint      axis [3][NAXIS];
        longint      grid [NGRID];
        logic [4:0]  npts [3];
        t_interp     pending_q [$];
        int          errors;

        function new();
            foreach (axis[a, k]) axis[a][k] = 0;
            foreach (grid[k]) grid[k] = 0;
            foreach (npts[a]) npts[a] = CFG_RESET;
            errors = 0;
        endfunction

        function int unsigned points(int a);
            if (npts[a] < 2) return 2;
            if (npts[a] > NAXIS) return NAXIS;
            return npts[a];
        endfunction

        function void set_points(int a, logic [4:0] v);
            npts[a] = v;
        endfunction

        // Lower-bound search, with the first-point case moved to cell 1.
        function int unsigned locate_cell(int a, longint c, output longint f);
            int unsigned n;
            int unsigned i;
            longint num, den, q;
            n = points(a);
            i = n - 1;
            for (int k = 0; k < n; k++) begin
                if (axis[a][k] >= c) begin
                    i = k;
                    break;
                end
            end
            if (i == 0) i = 1;
            num = c - axis[a][i-1];
            den = axis[a][i] - axis[a][i-1];
            if (den <= 0 || num <= 0) begin
                f = 0;
            end else begin
                q = (num <<< 16) / den;
                f = (q > ONE_Q16) ? ONE_Q16 : q;
            end
            return i;
        endfunction

        // Round half up, floor semantics through the arithmetic shift.
        function longint blend(longint p, longint q, longint f);
            longint s;
            s = p * (ONE_Q16 - f) + q * f + 32768;
            return s >>> 16;
        endfunction

        function void note_beat(t_beat b);
            t_interp r;
            longint x, y, z, fx, fy, fz;
            int unsigned nx, ny, nz, ix, iy, iz, sy, sx, pos;
            longint c00, c01, c10, c11;
            nx = points(0);
            ny = points(1);
            nz = points(2);
            if (b.cmd == CMD_LOAD_X || b.cmd == CMD_LOAD_Y || b.cmd == CMD_LOAD_Z) begin
                if (b.slot < NAXIS) axis[b.cmd][b.slot] = b.word;
                return;
            end
            if (b.cmd == CMD_LOAD_VAL) begin
                grid[b.slot] = b.word;
                return;
            end
            if (b.cmd != CMD_QUERY) return;
            x = b.x;
            y = b.y;
            z = b.z;
            if (!(x >= axis[0][0] && x <= axis[0][nx-1] &&
                  y >= axis[1][0] && y <= axis[1][ny-1] &&
                  z >= axis[2][0] && z <= axis[2][nz-1])) begin
                r.value = '0;
                r.in_range = 1'b0;
                pending_q.push_back(r);
                return;
            end
            ix = locate_cell(0, x, fx);
            iy = locate_cell(1, y, fy);
            iz = locate_cell(2, z, fz);
            sy = nz;
            sx = ny * nz;
            pos = (ix - 1) * sx + (iy - 1) * sy + (iz - 1);
            c00 = blend(grid[pos], grid[pos+1], fz);
            c01 = blend(grid[pos+sy], grid[pos+sy+1], fz);
            c10 = blend(grid[pos+sx], grid[pos+sx+1], fz);
            c11 = blend(grid[pos+sx+sy], grid[pos+sx+sy+1], fz);
            r.value = 32'(blend(blend(c00, c01, fy), blend(c10, c11, fy), fx));
            r.in_range = 1'b1;
            pending_q.push_back(r);
        endfunction

        function void check_result(logic signed [31:0] v, logic rng);
            t_interp e;
            if (pending_q.size() == 0) begin
                $error("unexpected result beat: interp_value %0d in_range %0b", v, rng);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (v !== e.value) begin
                $error("interp_value: expected %0d, actual %0d", e.value, v);
                errors++;
            end
            if (rng !== e.in_range) begin
                $error("in_range: expected %0b, actual %0b", e.in_range, rng);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [CMD_BITS-1:0]          i_cmd;
    logic [SLOT_BITS-1:0]         i_slot;
    logic signed [31:0]           i_load_word;
    logic signed [31:0]           i_query_x;
    logic signed [31:0]           i_query_y;
    logic signed [31:0]           i_query_z;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic signed [31:0]           o_interp_value;
    logic                         o_in_range;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]      i_cfg_index;
    logic [CFG_BITS-1:0]          i_cfg_data;

    interp_scoreboard sb = new();
    int burst_left = 1;
    longint cycles = 0;

    rectilinear_trilinear_interp_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_slot         (i_slot),
        .i_load_word    (i_load_word),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .i_query_z      (i_query_z),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_interp_value (o_interp_value),
        .o_in_range     (o_in_range),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the handshakes hang.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one beat and hold it until accepted. Close a burst with a random gap;
    // a zero gap keeps valid high so it is never dropped and raised in one step.
    task automatic send_beat(t_beat b);
        int gap;
        i_in_valid  <= 1'b1;
        i_cmd       <= b.cmd;
        i_slot      <= b.slot;
        i_load_word <= b.word;
        i_query_x   <= b.x;
        i_query_y   <= b.y;
        i_query_z   <= b.z;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(b);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drop valid, wait until every query has answered, then let loads drain.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_points(t_cfg_idx idx, logic [CFG_BITS-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_points(idx, v);
        @(posedge i_clk);
    endtask

    function automatic t_beat make_beat(logic [CMD_BITS-1:0] c, int s, longint w);
        t_beat b;
        b.cmd  = c;
        b.slot = s[SLOT_BITS-1:0];
        b.word = 32'(w);
        b.x    = $urandom;
        b.y    = $urandom;
        b.z    = $urandom;
        return b;
    endfunction

    function automatic t_beat make_query(longint x, longint y, longint z);
        t_beat b;
        b = make_beat(CMD_QUERY, $urandom, $urandom);
        b.x = 32'(x);
        b.y = 32'(y);
        b.z = 32'(z);
        return b;
    endfunction

    function automatic longint pick_between(longint lo, longint hi);
        longint unsigned span;
        longint t;
        if (hi < lo) begin
            t = lo;
            lo = hi;
            hi = t;
        end
        span = longint'(hi - lo) + 1;
        return lo + longint'({$urandom, $urandom} % span);
    endfunction

    // Coordinate on a grid point or inside a random cell of axis a.
    function automatic longint pick_coord(int a);
        int unsigned n, k;
        n = sb.points(a);
        k = $urandom_range(0, n - 2);
        case ($urandom_range(0, 3))
            0:       return sb.axis[a][k];
            1:       return sb.axis[a][n-1];
            default: return pick_between(sb.axis[a][k], sb.axis[a][k+1]);
        endcase
    endfunction

    // Write every axis point and grid entry that the current sizes can read.
    task automatic load_tables(bit ordered);
        int unsigned n;
        int vals [$];
        for (int a = 0; a < 3; a++) begin
            n = sb.points(a);
            vals.delete();
            for (int k = 0; k < n; k++) vals.push_back($urandom);
            if (ordered) vals.sort();
            for (int k = 0; k < n; k++) send_beat(make_beat(AXIS_CMD[a], k, vals[k]));
        end
        n = sb.points(0) * sb.points(1) * sb.points(2);
        for (int k = 0; k < n; k++)
            send_beat(make_beat(CMD_LOAD_VAL, k, $urandom_range(0, 1) ? $urandom
                                                 : $urandom_range(0, 20 * ONE_Q16)));
    endtask

    task automatic random_traffic(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                send_beat(make_beat($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI),
                                    $urandom, $urandom));
            else if (r < 8)
                send_beat(make_beat($urandom_range(CMD_LOAD_X, CMD_LOAD_Z),
                                    $urandom_range(NAXIS, 4095), $urandom));
            else if (r < 12)
                send_beat(make_beat(CMD_LOAD_VAL, $urandom_range(0, NGRID - 1), $urandom));
            else if (r < 30)
                send_beat(make_query(int'($urandom), int'($urandom), int'($urandom)));
            else
                send_beat(make_query(pick_coord(0), pick_coord(1), pick_coord(2)));
        end
    endtask

    task automatic run_phase(logic [4:0] px, logic [4:0] py, logic [4:0] pz, bit ordered);
        drain_pipeline();
        write_points(CFG_POINTS_X, px);
        write_points(CFG_POINTS_Y, py);
        write_points(CFG_POINTS_Z, pz);
        load_tables(ordered);
        random_traffic(100);
    endtask

    // Receiver: check accepted results, stall on a shifting pattern, and once
    // hold off long enough for the pipeline to fill and stall the input.
    initial begin
        int got, hold_left, mode;
        bit held;
        got = 0;
        hold_left = 0;
        held = 1'b0;
        mode = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_result(o_interp_value, o_in_range);
                got++;
            end
            if (cycles % 64 == 0) mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= (hold_left != 0);
            end else if (got >= HOLD_AFTER && !held) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= cycles[2];
                endcase
            end
        end
    end

    initial begin
        longint z0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_cmd       = CMD_LOAD_X;
        i_slot      = '0;
        i_load_word = '0;
        i_query_x   = '0;
        i_query_y   = '0;
        i_query_z   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_POINTS_X;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on a 2x2x2 grid: x spans the full word range, z is a
        // repeated point so its cell has zero width.
        z0 = 5 * ONE_Q16;
        write_points(CFG_POINTS_X, 5'd2);
        write_points(CFG_POINTS_Y, 5'd2);
        write_points(CFG_POINTS_Z, 5'd2);
        send_beat(make_beat(CMD_LOAD_X, 0, 32'sh8000_0000));
        send_beat(make_beat(CMD_LOAD_X, 1, 32'sh7fff_ffff));
        send_beat(make_beat(CMD_LOAD_Y, 0, -ONE_Q16));
        send_beat(make_beat(CMD_LOAD_Y, 1, ONE_Q16));
        send_beat(make_beat(CMD_LOAD_Z, 0, z0));
        send_beat(make_beat(CMD_LOAD_Z, 1, z0));
        for (int k = 0; k < 8; k++)
            send_beat(make_beat(CMD_LOAD_VAL, k, (k % 2) ? 32'sh7fff_ffff : 32'sh8000_0000));
        send_beat(make_beat(CMD_LOAD_VAL, 4095, 32'sh8000_0000));
        send_beat(make_beat(CMD_LOAD_X, 4095, 0));
        send_beat(make_beat(CMD_LOAD_Z, NAXIS, 0));
        send_beat(make_query(-64'sd2147483648, -ONE_Q16, z0));    // on every first point
        send_beat(make_query(64'sd2147483647, ONE_Q16, z0));      // on every last point
        send_beat(make_query(0, 0, z0));
        send_beat(make_query(ONE_Q16 / 2, ONE_Q16 / 3, z0));
        send_beat(make_query(0, 0, z0 - 1));                      // below z
        send_beat(make_query(0, 0, z0 + 1));                      // above z
        send_beat(make_query(0, -ONE_Q16 - 1, z0));
        send_beat(make_query(0, ONE_Q16 + 1, z0));
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            send_beat(make_beat(c, $urandom, $urandom));

        // Random phases, sizes at both extremes and clamped register values.
        run_phase(5'd16, 5'd2, 5'd3, 1'b1);
        run_phase(5'd0, 5'd31, 5'd1, 1'b1);
        run_phase(5'd2, 5'd4, 5'd16, 1'b1);
        run_phase(5'd5, 5'd4, 5'd3, 1'b0);
        run_phase(5'd17, 5'd3, 5'd2, 1'b1);
        run_phase(5'd3, 5'd5, 5'd4, 1'b1);

        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
